>>> hdl/pott_pkg.sv
// ----------------------------------------------------------------------------
// pott_pkg
// Shared types and constants of the periodic / one-shot timer table.
// ----------------------------------------------------------------------------
package pott_pkg;

  // Table geometry and time width
  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  // Fixed field widths of the transaction payloads
  localparam int ACT_W     = 3;
  localparam int TIDX_W    = 4;
  localparam int FIELD_T_W = 32;
  localparam int RIDX_W    = 5;

  // Action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD     = 3'd0,
    ACT_SET     = 3'd1,
    ACT_START   = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_RESTART = 3'd4,
    ACT_TICK    = 3'd5,
    ACT_CLEAR   = 3'd6
  } act_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_FIRE = 2'd2
  } kind_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_ARM,
    S_UPD,
    S_FIN
  } state_t;

  // Input transaction
  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [TIDX_W-1:0]    timer_index;
    logic [FIELD_T_W-1:0] period_ms;
    logic                 run_at_add;
    logic                 one_shot;
    logic [FIELD_T_W-1:0] now_ms;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]        kind;
    logic [RIDX_W-1:0] result_index;
    logic [1:0]        status;
    logic              last;
  } out_t;

  // Write side of the period / deadline store
  typedef struct packed {
    logic                 per_we;
    logic                 dl_we;
    logic [IDX_W-1:0]     addr;
    logic [TIME_BITS-1:0] per_data;
    logic [TIME_BITS-1:0] dl_data;
  } store_wr_t;

  // Build one result transaction
  function automatic out_t make_out(kind_t k, logic [RIDX_W-1:0] idx, status_t s,
                                    logic lst);
    out_t o;
    o.kind         = k;
    o.result_index = idx;
    o.status       = s;
    o.last         = lst;
    return o;
  endfunction

endpackage

>>> hdl/pott_store.sv
// ----------------------------------------------------------------------------
// pott_store
// Period and deadline memories: one write port, one registered read port each.
// ----------------------------------------------------------------------------
module pott_store (
  input  logic                           clk,
  input  logic [pott_pkg::IDX_W-1:0]     rd_addr,
  input  pott_pkg::store_wr_t            wr,
  output logic [pott_pkg::TIME_BITS-1:0] rd_per_r,
  output logic [pott_pkg::TIME_BITS-1:0] rd_dl_r
);
  import pott_pkg::*;

  logic [TIME_BITS-1:0] per_mem [NUM_TIMERS];
  logic [TIME_BITS-1:0] dl_mem  [NUM_TIMERS];

  // Period memory
  always_ff @(posedge clk) begin
    if (wr.per_we) begin
      per_mem[wr.addr] <= wr.per_data;
    end
    rd_per_r <= per_mem[rd_addr];
  end

  // Deadline memory
  always_ff @(posedge clk) begin
    if (wr.dl_we) begin
      dl_mem[wr.addr] <= wr.dl_data;
    end
    rd_dl_r <= dl_mem[rd_addr];
  end

endmodule

>>> hdl/periodic_oneshot_timer_table_top.sv
// A command is taken into the request register in S_IDLE; its result is
// registered in S_CMD once the result register is free. A tick takes each entry
// through S_ARM and S_UPD (the deadline memory's read-modify-write), then S_FIN,
// and holds while results stall. Synchronous active-low reset clears counts,
// run/one-shot/done bits and result valid; memories are not cleared.
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_table_top
// Timer table: commands edit one entry, a tick walks all entries through the
// memories and reports each timer that fires.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_table_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pott_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pott_pkg::out_t out_data
);
  import pott_pkg::*;

  state_t                state_r, state_nxt;
  in_t                   req_r, req_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  tick_en_r, tick_en_nxt;
  logic [NUM_TIMERS-1:0] run_r, run_nxt;
  logic [NUM_TIMERS-1:0] shot_r, shot_nxt;
  logic [NUM_TIMERS-1:0] done_r, done_nxt;
  logic [IDX_W-1:0]      walk_r, walk_nxt;
  logic [TIME_BITS-1:0]  arm_r, arm_nxt;
  logic [TIME_BITS-1:0]  per_r, per_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  logic [IDX_W-1:0]      rd_addr;
  store_wr_t             wr;
  logic [TIME_BITS-1:0]  rd_per_r, rd_dl_r;

  logic                  out_free;
  logic [TIME_BITS-1:0]  now_t, req_per_t, new_dl;
  logic [IDX_W-1:0]      req_idx, cnt_idx;
  logic                  in_range, reached, fire, blocked, last_entry;

  // Memories
  pott_store u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .rd_per_r (rd_per_r),
    .rd_dl_r  (rd_dl_r)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tick_en_r   <= 1'b0;
      run_r       <= '0;
      shot_r      <= '0;
      done_r      <= '0;
      walk_r      <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tick_en_r   <= tick_en_nxt;
      run_r       <= run_nxt;
      shot_r      <= shot_nxt;
      done_r      <= done_nxt;
      walk_r      <= walk_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    arm_r      <= arm_nxt;
    per_r      <= per_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // Common decode
  assign out_free   = !out_valid_r || !out_stall;
  assign now_t      = TIME_BITS'(req_r.now_ms);
  assign req_per_t  = TIME_BITS'(req_r.period_ms);
  assign req_idx    = IDX_W'(req_r.timer_index);
  assign cnt_idx    = count_r[IDX_W-1:0];
  assign in_range   = CNT_W'(req_r.timer_index) < count_r;
  assign reached    = now_t >= arm_r;
  assign new_dl     = reached ? (arm_r + per_r) : arm_r;
  assign fire       = reached && run_r[walk_r] && !done_r[walk_r];
  assign blocked    = fire && pend_vld_r && !out_free;
  assign last_entry = (CNT_W'(walk_r) + CNT_W'(1)) == count_r;
  assign rd_addr    = (state_r == S_UPD) ? walk_r + IDX_W'(1) : walk_r;

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    tick_en_nxt   = tick_en_r;
    run_nxt       = run_r;
    shot_nxt      = shot_r;
    done_nxt      = done_r;
    walk_nxt      = walk_r;
    arm_nxt       = arm_r;
    per_nxt       = per_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr            = '0;
    in_stall      = (state_r != S_IDLE);

    unique case (state_r)
      // Take a transaction; the read of entry 0 is already under way
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          walk_nxt = '0;
          unique case (act_t'(in_data.action))
            ACT_ADD, ACT_SET, ACT_START, ACT_STOP, ACT_RESTART, ACT_CLEAR: begin
              state_nxt = S_CMD;
            end
            ACT_TICK: begin
              if (tick_en_r && (count_r != '0)) begin
                state_nxt = S_ARM;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Execute a command once the result register is free
      S_CMD: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = make_out(KIND_ACK, '0, ST_OK, 1'b1);
          unique case (act_t'(req_r.action))
            ACT_ADD: begin
              tick_en_nxt = 1'b1;
              if (req_per_t == '0) begin
                out_data_nxt = make_out(KIND_ADD, RIDX_W'(count_r), ST_ZERO, 1'b1);
              end else if (count_r >= CNT_W'(NUM_TIMERS)) begin
                out_data_nxt = make_out(KIND_ADD, RIDX_W'(count_r), ST_FULL, 1'b1);
              end else begin
                out_data_nxt      = make_out(KIND_ADD, RIDX_W'(count_r), ST_OK, 1'b1);
                wr.per_we         = 1'b1;
                wr.dl_we          = 1'b1;
                wr.addr           = cnt_idx;
                wr.per_data       = req_per_t;
                wr.dl_data        = '0;
                run_nxt[cnt_idx]  = req_r.run_at_add;
                shot_nxt[cnt_idx] = req_r.one_shot;
                done_nxt[cnt_idx] = 1'b0;
                count_nxt         = count_r + CNT_W'(1);
              end
            end
            ACT_SET, ACT_START, ACT_STOP, ACT_RESTART: begin
              if (!in_range) begin
                out_data_nxt = make_out(KIND_ACK, '0, ST_RANGE, 1'b1);
              end else begin
                wr.addr     = req_idx;
                wr.per_data = req_per_t;
                wr.dl_data  = '0;
                unique case (act_t'(req_r.action))
                  ACT_SET: begin
                    wr.per_we = 1'b1;
                  end
                  ACT_START: begin
                    wr.dl_we          = 1'b1;
                    run_nxt[req_idx]  = 1'b1;
                    done_nxt[req_idx] = 1'b0;
                  end
                  ACT_STOP: begin
                    run_nxt[req_idx] = 1'b0;
                  end
                  default: begin
                    wr.dl_we = 1'b1;
                  end
                endcase
              end
            end
            default: begin
              // clear table
              count_nxt   = '0;
              tick_en_nxt = 1'b0;
              run_nxt     = '0;
              shot_nxt    = '0;
              done_nxt    = '0;
            end
          endcase
        end
      end

      // Read data in: arm an unarmed entry
      S_ARM: begin
        per_nxt   = rd_per_r;
        arm_nxt   = (rd_dl_r == '0) ? now_t + rd_per_r : rd_dl_r;
        state_nxt = S_UPD;
      end

      // Compare, write back, report; a fired entry is held until the next
      // one shows whether it was the last
      S_UPD: begin
        if (!blocked) begin
          wr.dl_we   = 1'b1;
          wr.addr    = walk_r;
          wr.dl_data = new_dl;
          if (reached && shot_r[walk_r]) begin
            done_nxt[walk_r] = 1'b1;
          end
          if (fire) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = make_out(KIND_FIRE, RIDX_W'(pend_idx_r), ST_OK, 1'b0);
            end
            pend_vld_nxt = 1'b1;
            pend_idx_nxt = walk_r;
          end
          if (last_entry) begin
            walk_nxt  = '0;
            state_nxt = S_FIN;
          end else begin
            walk_nxt  = walk_r + IDX_W'(1);
            state_nxt = S_ARM;
          end
        end
      end

      // Flush the held fired entry, marked last
      S_FIN: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = make_out(KIND_FIRE, RIDX_W'(pend_idx_r), ST_OK, 1'b1);
          pend_vld_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/pott_checker.sv
// ----------------------------------------------------------------------------
// pott_checker
// Port-level checks of the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module pott_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input pott_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input pott_pkg::out_t out_data
);
  import pott_pkg::*;

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Command replies are single transactions with no fired-entry index mixed in
  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != KIND_FIRE) |-> out_data.last)
    else $error("command reply not marked last");

  // A fired entry always carries status ok and an index inside the table
  a_fire_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_FIRE) |->
      (out_data.status == ST_OK) && (out_data.result_index < RIDX_W'(NUM_TIMERS)))
    else $error("bad fired result fields");

  // An accepted add keeps the block busy for its execution cycle
  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.action == ACT_ADD) |=> in_stall)
    else $error("add accepted without a busy cycle");

endmodule

bind periodic_oneshot_timer_table_top pott_checker u_pott_checker (.*);
